@@ rtl/btws_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helpers of the block transfer window server
// no dependencies
package btws_pkg;

    localparam int MAX_BLOCKS   = 1024;
    localparam int WINDOW_LIMIT = 63;

    localparam int MAP_W    = (MAX_BLOCKS < 32) ? MAX_BLOCKS : 32;
    localparam int MAP_ROWS = MAX_BLOCKS / MAP_W;
    localparam int BIT_AW   = $clog2(MAP_W);
    localparam int ROW_AW   = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int POS_W    = 17;

    localparam logic [1:0] FUNC_RX  = 2'd0;
    localparam logic [1:0] FUNC_MSG = 2'd1;
    localparam logic [1:0] FUNC_TMO = 2'd2;

    localparam logic [1:0] ST_OPEN  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_SENT  = 2'd2;
    localparam logic [1:0] ST_ABORT = 2'd3;

    localparam int FL_SENT_ALL = 0;
    localparam int FL_RX_ALL   = 1;
    localparam int FL_COMPOSED = 2;
    localparam int FL_RX_LAST  = 3;
    localparam int FL_WIN_END  = 4;
    localparam int FL_PKT_SENT = 5;

    localparam logic [7:0] CTL_WIN_MASK = 8'h3F;
    localparam logic [7:0] CTL_LAST     = 8'h80;
    localparam logic [7:0] CTL_NO_STRM  = 8'hBF;
    localparam logic [7:0] CTL_STRM     = 8'h40;

    localparam logic [2:0] REG_ADDR_W = 3'd3;

    typedef enum logic [2:0] {
        C_ABORT, C_RX, C_MSG, C_TMO, C_NONE
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [7:0]  ctl;
        logic [15:0] bn;
        logic [15:0] bna;
        logic [15:0] plen;
        logic [23:0] msize;
    } q_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ctl;
        logic [15:0] bn;
        logic [15:0] ack;
        logic [23:0] off;
        logic [23:0] len;
        logic [2:0]  lb;
        logic [1:0]  status;
        logic [23:0] total;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [5:0]  max_window;
        logic [15:0] payload_size;
    } cfg_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_RD2, S_ADV, S_POST, S_POST2, S_MANAGE,
        S_SCAN_A, S_SCAN_B, S_WIN, S_MUL, S_SEND, S_SENT, S_STATUS, S_ABORT
    } state_t;

    function automatic logic [2:0] length_bytes_of(input logic [23:0] len);
        if (len <= 24'd127) return 3'd1;
        else if (len <= 24'd255) return 3'd2;
        else if (len <= 24'd65535) return 3'd3;
        else return 3'd4;
    endfunction

endpackage

@@ rtl/block_transfer_window_server.sv @@
`timescale 1ns / 1ps
// Server side of a windowed block transfer. Each input word is a received frame
// header, a new outgoing message or a retransmit timeout; the block answers with
// zero or more frame header words (payload given as offset and length into the
// outgoing message) and always one closing status word with last set. Items are
// handled one at a time by a sequencer behind a two-entry input queue. A search of
// the received-block map steps through it one 32-entry row at a time (up to three
// searches for a received frame), and a stall on the result side holds the send loop.
// After reset, and after an abort request, a clearing pass wipes all 32 rows of the
// map before the next word is taken.
// Configuration: max_window at byte address 0, block_payload_size at address 4.
// depends on btws_pkg, btws_front, btws_back
module block_transfer_window_server import btws_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_block_control,
    input  logic [15:0] s_block_number,
    input  logic [15:0] s_block_number_ack,
    input  logic [15:0] s_payload_size,
    input  logic [23:0] s_message_size,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_tx_block_control,
    output logic [15:0] m_tx_block_number,
    output logic [15:0] m_tx_block_ack,
    output logic [23:0] m_tx_offset,
    output logic [23:0] m_tx_length,
    output logic [2:0]  m_length_bytes,
    output logic [1:0]  m_status,
    output logic [23:0] m_received_total,
    output logic        m_last
);
    cfg_t      cfg_reg, cfg_next;
    logic      q_valid, q_pop;
    q_item_t   q_item;
    out_item_t m_item;

    // register file: written on the access phase, pready tied high
    assign pready = 1'b1;
    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            if (paddr[2]) cfg_next.payload_size = pwdata[15:0];
            else cfg_next.max_window = pwdata[5:0];
        end
        prdata = paddr[2] ? {16'd0, cfg_reg.payload_size} : {26'd0, cfg_reg.max_window};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_window   <= 6'd1;
            cfg_reg.payload_size <= 16'd118;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and classify, queue towards the sequencer
    btws_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_block_control    (s_block_control),
        .s_block_number     (s_block_number),
        .s_block_number_ack (s_block_number_ack),
        .s_payload_size     (s_payload_size),
        .s_message_size     (s_message_size),
        .q_valid            (q_valid),
        .q_item             (q_item),
        .q_pop              (q_pop)
    );

    // back: map searches, send loop and the output register
    btws_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    assign m_kind             = m_item.kind;
    assign m_tx_block_control = m_item.ctl;
    assign m_tx_block_number  = m_item.bn;
    assign m_tx_block_ack     = m_item.ack;
    assign m_tx_offset        = m_item.off;
    assign m_tx_length        = m_item.len;
    assign m_length_bytes     = m_item.lb;
    assign m_status           = m_item.status;
    assign m_received_total   = m_item.total;
    assign m_last             = m_item.last;
endmodule

@@ rtl/btws_ram.sv @@
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies
module btws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/btws_front.sv @@
`timescale 1ns / 1ps
// front end: accepts input words, classifies them, two-entry queue
// depends on btws_pkg
module btws_front import btws_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_block_control,
    input  logic [15:0] s_block_number,
    input  logic [15:0] s_block_number_ack,
    input  logic [15:0] s_payload_size,
    input  logic [23:0] s_message_size,
    output logic        q_valid,
    output q_item_t     q_item,
    input  logic        q_pop
);
    q_item_t    ent_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    q_item_t    new_item;
    logic       push;

    always_comb begin
        new_item.ctl   = s_block_control;
        new_item.bn    = s_block_number;
        new_item.bna   = s_block_number_ack;
        new_item.plen  = s_payload_size;
        new_item.msize = s_message_size;
        case (s_func)
            FUNC_RX: begin
                if (s_block_control[7:6] == 2'b10 && s_block_number == 16'd0
                    && s_block_number_ack == 16'd0) begin
                    new_item.cls = C_ABORT;
                end else begin
                    new_item.cls = C_RX;
                end
            end
            FUNC_MSG: new_item.cls = C_MSG;
            FUNC_TMO: new_item.cls = C_TMO;
            default:  new_item.cls = C_NONE;
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = ent_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
        rd_next  = rd_reg ^ q_pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
        if (push) begin
            ent_reg[wr_reg] <= new_item;
        end
    end
endmodule

@@ rtl/btws_back.sv @@
`timescale 1ns / 1ps
// back end: sequencer over the received-block map, send loop, output register
// depends on btws_pkg, btws_ram
module btws_back import btws_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  q_item_t   q_item,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    q_item_t     it_reg, it_next;
    logic [15:0] top_reg, top_next;
    logic [5:0]  pw_reg, pw_next;
    logic [15:0] pack_reg, pack_next;
    logic [15:0] fsb_reg, fsb_next;
    logic [23:0] olen_reg, olen_next;
    logic [5:0]  flags_reg, flags_next;
    logic [23:0] rx_reg, rx_next;
    logic        tmo_reg, tmo_next;
    logic        post_reg, post_next;
    logic        comp_reg, comp_next;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              zero_reg, zero_next;
    logic              found_reg, found_next;
    logic [ROW_AW-1:0] clr_reg, clr_next;

    logic [5:0]  win_reg, win_next;
    logic [15:0] k_reg, k_next;
    logic        ge_reg, ge_next;
    logic [33:0] off_reg, off_next;
    logic        data_reg, data_next;
    logic [7:0]  ctl_reg, ctl_next;
    logic [6:0]  i_reg, i_next;

    logic      mv_reg, mv_next;
    out_item_t mo_reg, mo_next;

    logic              ram_we;
    logic [ROW_AW-1:0] ram_waddr, ram_raddr;
    logic [MAP_W-1:0]  ram_wdata, ram_rdata;

    logic              out_free;
    logic [MAP_W-1:0]  srch;
    logic              hit;
    logic [BIT_AW-1:0] hit_idx;
    logic [ROW_AW-1:0] pos_row;
    logic [BIT_AW-1:0] pos_bit;
    logic              dup;
    logic [24:0]       rx_sum;
    logic [POS_W-1:0]  need;
    logic [31:0]       prod;
    logic [33:0]       off_end;
    logic [7:0]        ctl_step;

    btws_ram #(.WIDTH(MAP_W), .DEPTH(MAP_ROWS)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !mv_reg || m_ready;
    assign m_valid  = mv_reg;
    assign m_item   = mo_reg;
    assign pos_row  = pos_reg[BIT_AW +: ROW_AW];
    assign pos_bit  = pos_reg[BIT_AW-1:0];
    assign dup      = ram_rdata[it_reg.bn[BIT_AW-1:0]];
    assign rx_sum   = {1'b0, rx_reg} + {9'd0, it_reg.plen};
    assign need     = pos_reg - {1'b0, top_reg} - POS_W'(1);
    assign prod     = k_reg * cfg.payload_size;
    assign off_end  = off_reg + {18'd0, cfg.payload_size};
    assign ctl_step = ({1'b0, i_reg[5:0]} == {1'b0, pw_reg} && i_reg[6] == 1'b0)
                      ? (ctl_reg & CTL_NO_STRM) : ctl_reg;

    // first set bit of the masked row (zeros searched through inversion)
    always_comb begin
        srch = zero_reg ? ~ram_rdata : ram_rdata;
        for (int b = 0; b < MAP_W; b++) begin
            if (BIT_AW'(b) < pos_bit) srch[b] = 1'b0;
        end
        hit     = 1'b0;
        hit_idx = '0;
        for (int b = MAP_W - 1; b >= 0; b--) begin
            if (srch[b]) begin
                hit     = 1'b1;
                hit_idx = BIT_AW'(b);
            end
        end
    end

    always_comb begin
        ram_raddr = pos_row;
        if (state_reg == S_RD) ram_raddr = it_reg.bn[BIT_AW +: ROW_AW];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (clr_reg == ROW_AW'(MAP_ROWS - 1)) state_next = S_IDLE;
            S_IDLE: begin
                if (q_valid) begin
                    case (q_item.cls)
                        C_ABORT: state_next = S_ABORT;
                        C_RX: begin
                            if (q_item.bn < 16'(MAX_BLOCKS)) state_next = S_RD;
                            else state_next = S_POST;
                        end
                        C_MSG, C_TMO: state_next = S_MANAGE;
                        default: state_next = S_STATUS;
                    endcase
                end
            end
            S_RD: state_next = S_RD2;
            S_RD2: begin
                if (!dup && it_reg.bn != 16'd0 && it_reg.bn == top_reg + 16'd1)
                    state_next = S_SCAN_A;
                else state_next = S_POST;
            end
            S_ADV: state_next = S_POST;
            S_POST: state_next = (it_reg.plen == 16'd0) ? S_MANAGE : S_SCAN_A;
            S_POST2: begin
                if (flags_next[FL_WIN_END] || flags_next[FL_RX_ALL]) state_next = S_MANAGE;
                else state_next = S_STATUS;
            end
            S_MANAGE: begin
                if (tmo_reg) state_next = flags_reg[FL_SENT_ALL] ? S_STATUS : S_SCAN_A;
                else if (flags_reg[FL_RX_ALL] && !flags_reg[FL_COMPOSED])
                    state_next = S_STATUS;
                else state_next = S_SCAN_A;
            end
            S_SCAN_A: state_next = (pos_reg >= POS_W'(MAX_BLOCKS)) ? ret_reg : S_SCAN_B;
            S_SCAN_B: begin
                if (hit || pos_row == ROW_AW'(MAP_ROWS - 1)) state_next = ret_reg;
                else state_next = S_SCAN_A;
            end
            S_WIN: state_next = S_MUL;
            S_MUL: state_next = S_SEND;
            S_SEND: begin
                if (!data_reg) begin
                    if (out_free) state_next = S_SENT;
                end else if (i_reg > {1'b0, pw_reg} || i_reg > 7'(WINDOW_LIMIT)) begin
                    state_next = S_SENT;
                end else if (out_free && off_end >= {10'd0, olen_reg}) begin
                    state_next = S_SENT;
                end
            end
            S_SENT: state_next = S_STATUS;
            S_STATUS: if (out_free) state_next = S_IDLE;
            S_ABORT: if (out_free) state_next = S_CLEAR;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        it_next = it_reg;     top_next = top_reg;   pw_next = pw_reg;
        pack_next = pack_reg; fsb_next = fsb_reg;   olen_next = olen_reg;
        flags_next = flags_reg; rx_next = rx_reg;   tmo_next = tmo_reg;
        post_next = post_reg; comp_next = comp_reg; pos_next = pos_reg;
        zero_next = zero_reg; found_next = found_reg; clr_next = clr_reg;
        ret_next = ret_reg;   win_next = win_reg;   k_next = k_reg;
        ge_next = ge_reg;     off_next = off_reg;   data_next = data_reg;
        ctl_next = ctl_reg;   i_next = i_reg;
        mv_next = mv_reg && !m_ready;
        mo_next = mo_reg;
        q_pop = 1'b0;
        ram_we = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        case (state_reg)
            S_CLEAR: begin
                ram_we   = 1'b1;
                clr_next = clr_reg + ROW_AW'(1);
            end
            S_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    it_next   = q_item;
                    tmo_next  = (q_item.cls == C_TMO);
                    post_next = 1'b0;
                    comp_next = 1'b0;
                    if (q_item.cls == C_RX) begin
                        pw_next   = q_item.ctl[5:0];
                        pack_next = q_item.bna;
                        flags_next[FL_PKT_SENT] = 1'b0;
                    end
                    if (q_item.cls == C_MSG) begin
                        olen_next = q_item.msize;
                        fsb_next  = pack_reg + 16'd1;
                    end
                end
            end
            S_RD2: begin
                if (!dup) begin
                    ram_we    = 1'b1;
                    ram_waddr = it_reg.bn[BIT_AW +: ROW_AW];
                    ram_wdata = ram_rdata | (MAP_W'(1) << it_reg.bn[BIT_AW-1:0]);
                    rx_next   = rx_sum[24] ? 24'hFFFFFF : rx_sum[23:0];
                end
                pos_next  = {1'b0, top_reg} + POS_W'(1);
                zero_next = 1'b1;
                ret_next  = S_ADV;
            end
            S_ADV: begin
                top_next = found_reg ? 16'(pos_reg - POS_W'(1)) : 16'(MAX_BLOCKS - 1);
            end
            S_POST: begin
                pos_next  = {1'b0, top_reg} + POS_W'(1);
                zero_next = 1'b0;
                ret_next  = S_POST2;
            end
            S_POST2: begin
                if (it_reg.ctl[7]) flags_next[FL_RX_LAST] = 1'b1;
                if (!it_reg.ctl[6]) flags_next[FL_WIN_END] = 1'b1;
                flags_next[FL_RX_ALL] = flags_next[FL_RX_LAST] && !found_reg;
                post_next = 1'b1;
            end
            S_MANAGE: begin
                pos_next  = {1'b0, top_reg} + POS_W'(1);
                zero_next = 1'b0;
                ret_next  = S_WIN;
                if (!tmo_reg && flags_reg[FL_RX_ALL] && !flags_reg[FL_COMPOSED]) begin
                    flags_next[FL_COMPOSED] = 1'b1;
                    comp_next = post_reg;
                end
            end
            S_SCAN_A: begin
                if (pos_reg >= POS_W'(MAX_BLOCKS)) found_next = 1'b0;
            end
            S_SCAN_B: begin
                if (hit) begin
                    found_next = 1'b1;
                    pos_next   = {pos_reg[POS_W-1:BIT_AW], hit_idx};
                end else if (pos_row == ROW_AW'(MAP_ROWS - 1)) begin
                    found_next = 1'b0;
                end else begin
                    pos_next = {pos_reg[POS_W-1:BIT_AW] + (POS_W - BIT_AW)'(1),
                                {BIT_AW{1'b0}}};
                end
            end
            S_WIN: begin
                if (found_reg && need < {11'd0, cfg.max_window}) win_next = need[5:0];
                else win_next = cfg.max_window;
                k_next  = pack_reg + 16'd1 - fsb_reg;
                ge_next = (pack_reg + 16'd1) >= fsb_reg;
            end
            S_MUL: begin
                off_next  = {2'd0, prod};
                data_next = olen_reg != 24'd0 && ge_reg && prod < {8'd0, olen_reg};
                ctl_next  = CTL_STRM | {2'b00, win_reg};
                i_next    = 7'd1;
            end
            S_SEND: begin
                if (!data_reg) begin
                    if (out_free) begin
                        mv_next        = 1'b1;
                        mo_next        = '0;
                        mo_next.ctl    = CTL_LAST | {2'b00, win_reg};
                        mo_next.bn     = pack_reg + 16'd1;
                        mo_next.ack    = top_reg;
                        mo_next.lb     = 3'd1;
                    end
                end else if (!(i_reg > {1'b0, pw_reg} || i_reg > 7'(WINDOW_LIMIT))
                             && out_free) begin
                    mv_next     = 1'b1;
                    mo_next     = '0;
                    mo_next.bn  = pack_reg + 16'd1 + 16'(i_reg) - 16'd1;
                    mo_next.ack = top_reg;
                    mo_next.off = off_reg[23:0];
                    if (off_end >= {10'd0, olen_reg}) begin
                        mo_next.ctl = (ctl_reg | CTL_LAST) & CTL_NO_STRM;
                        mo_next.len = olen_reg - off_reg[23:0];
                        flags_next[FL_SENT_ALL] = 1'b1;
                    end else begin
                        mo_next.ctl = ctl_step;
                        mo_next.len = {8'd0, cfg.payload_size};
                        ctl_next    = ctl_step;
                        off_next    = off_end;
                        i_next      = i_reg + 7'd1;
                    end
                    mo_next.lb = length_bytes_of(mo_next.len);
                end
            end
            S_SENT: begin
                flags_next[FL_PKT_SENT] = 1'b1;
                flags_next[FL_WIN_END]  = 1'b0;
            end
            S_STATUS: begin
                if (out_free) begin
                    mv_next       = 1'b1;
                    mo_next       = '0;
                    mo_next.kind  = 1'b1;
                    mo_next.lb    = 3'd1;
                    mo_next.total = rx_reg;
                    mo_next.last  = 1'b1;
                    if (it_reg.cls == C_NONE) mo_next.status = ST_OPEN;
                    else if (flags_reg[FL_PKT_SENT]) mo_next.status = ST_SENT;
                    else if (comp_reg) mo_next.status = ST_DONE;
                    else mo_next.status = ST_OPEN;
                end
            end
            S_ABORT: begin
                if (out_free) begin
                    mv_next        = 1'b1;
                    mo_next        = '0;
                    mo_next.kind   = 1'b1;
                    mo_next.lb     = 3'd1;
                    mo_next.status = ST_ABORT;
                    mo_next.last   = 1'b1;
                    top_next = '0; pw_next = 6'd1; pack_next = '0; fsb_next = '0;
                    olen_next = '0; flags_next = '0; rx_next = '0; clr_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            top_reg   <= '0;
            pw_reg    <= 6'd1;
            pack_reg  <= '0;
            fsb_reg   <= '0;
            olen_reg  <= '0;
            flags_reg <= '0;
            rx_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            top_reg   <= top_next;
            pw_reg    <= pw_next;
            pack_reg  <= pack_next;
            fsb_reg   <= fsb_next;
            olen_reg  <= olen_next;
            flags_reg <= flags_next;
            rx_reg    <= rx_next;
            mv_reg    <= mv_next;
        end
        ret_reg   <= ret_next;
        it_reg    <= it_next;
        tmo_reg   <= tmo_next;
        post_reg  <= post_next;
        comp_reg  <= comp_next;
        pos_reg   <= pos_next;
        zero_reg  <= zero_next;
        found_reg <= found_next;
        win_reg   <= win_next;
        k_reg     <= k_next;
        ge_reg    <= ge_next;
        off_reg   <= off_next;
        data_reg  <= data_next;
        ctl_reg   <= ctl_next;
        i_reg     <= i_next;
        mo_reg    <= mo_next;
    end
endmodule

@@ rtl/btws_checker.sv @@
`timescale 1ns / 1ps
// port-level checks of the block transfer window server, bound to the top level
// depends on block_transfer_window_server
module btws_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_kind,
    input logic [2:0] m_length_bytes,
    input logic [1:0] m_status,
    input logic       m_last
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");
    a_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> !m_last && m_status == 2'd0)
        else $error("frame word with status or last");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> m_last && m_length_bytes == 3'd1)
        else $error("status word malformed");
    a_lb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_length_bytes != 3'd0 && m_length_bytes <= 3'd4)
        else $error("length field size out of range");
endmodule

bind block_transfer_window_server btws_checker u_btws_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kind         (m_kind),
    .m_length_bytes (m_length_bytes),
    .m_status       (m_status),
    .m_last         (m_last)
);
